>>> design/dcss_pkg.sv
// Shared types and constants of the double-clap stepper switch.
package dcss_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int GAP_BITS    = 12;
    localparam int THRESH_BITS = 10;
    localparam int PULSE_BITS  = 8;
    localparam int ROUND_BITS  = 8;
    localparam int COIL_BITS   = 4;
    localparam int PHASE_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = (GAP_BITS > THRESH_BITS) ? GAP_BITS : THRESH_BITS;
    localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    localparam logic [THRESH_BITS-1:0] HIGH_THR_RST    = THRESH_BITS'(750);
    localparam logic [THRESH_BITS-1:0] LOW_THR_RST     = THRESH_BITS'(400);
    localparam logic [PULSE_BITS-1:0]  PULSE_WIN_RST   = PULSE_BITS'(10);
    localparam logic [GAP_BITS-1:0]    GAP_WIN_RST     = GAP_BITS'(300);
    localparam logic [ROUND_BITS-1:0]  RUN_ROUNDS_RST  = ROUND_BITS'(30);

    typedef enum logic [1:0] {
        DET_IDLE   = 2'd0,
        DET_FIRST  = 2'd1,
        DET_GAP    = 2'd2,
        DET_SECOND = 2'd3
    } t_detect;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HIGH_THR   = 3'd0,
        CFG_LOW_THR    = 3'd1,
        CFG_PULSE_WIN  = 3'd2,
        CFG_GAP_WIN    = 3'd3,
        CFG_RUN_ROUNDS = 3'd4
    } t_cfg_reg;

endpackage

>>> design/double_clap_stepper_switch.sv
// Double-clap detector that drives a four-coil stepper and a light flag.
//
//  channel  | valid            | ready            | payload
//  ---------+------------------+------------------+-----------------------------------------
//  sample   | i_sample_valid   | o_sample_ready   | i_sample
//  result   | o_result_valid   | i_result_ready   | o_coil_drive o_light_on o_moving o_reverse
//  config   | i_cfg_we         | (none)           | i_cfg_index i_cfg_data
//
// One sample word in, one registered result word out; a new word is
// taken every cycle the result register is empty or being drained.
// Detector and motor state update in the cycle a sample is taken, all compares
// and counter steps sit between the state registers and the result register.
// Synchronous reset clears control state and loads the register defaults.
// A stalled result holds; the sample side stalls only while it is held.
module double_clap_stepper_switch (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic [dcss_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic [dcss_pkg::COIL_BITS-1:0]      o_coil_drive,
    output logic                                o_light_on,
    output logic                                o_moving,
    output logic                                o_reverse,
    input  logic                                i_cfg_we,
    input  logic [dcss_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dcss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import dcss_pkg::*;

    // configuration registers
    logic [THRESH_BITS-1:0] r_high_thr;
    logic [THRESH_BITS-1:0] r_low_thr;
    logic [PULSE_BITS-1:0]  r_pulse_win;
    logic [GAP_BITS-1:0]    r_gap_win;
    logic [ROUND_BITS-1:0]  r_run_rounds;

    // detector and motor state
    t_detect                r_detect, n_detect;
    logic [GAP_BITS-1:0]    r_window_count, n_window_count;
    logic                   r_light, n_light;
    logic                   r_run_active, n_run_active;
    logic                   r_run_dir, n_run_dir;
    logic [PHASE_BITS-1:0]  r_phase, n_phase;
    logic [ROUND_BITS-1:0]  r_round, n_round;

    // result register
    logic                   r_out_valid, n_out_valid;
    logic [COIL_BITS-1:0]   r_coil, n_coil;
    logic                   r_light_out, n_light_out;
    logic                   r_moving, n_moving;
    logic                   r_reverse, n_reverse;

    logic                   accept;
    logic                   above_high;
    logic                   below_low;
    logic [GAP_BITS-1:0]    count_inc;
    logic [GAP_BITS-1:0]    pulse_limit;
    logic                   pulse_out;
    logic                   gap_out;
    logic [PHASE_BITS-1:0]  phase_sel;
    logic [ROUND_BITS-1:0]  round_inc;

    assign o_sample_ready = !r_out_valid || i_result_ready;
    assign accept         = i_sample_valid && o_sample_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr   <= HIGH_THR_RST;
            r_low_thr    <= LOW_THR_RST;
            r_pulse_win  <= PULSE_WIN_RST;
            r_gap_win    <= GAP_WIN_RST;
            r_run_rounds <= RUN_ROUNDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HIGH_THR:   r_high_thr   <= i_cfg_data[THRESH_BITS-1:0];
                CFG_LOW_THR:    r_low_thr    <= i_cfg_data[THRESH_BITS-1:0];
                CFG_PULSE_WIN:  r_pulse_win  <= i_cfg_data[PULSE_BITS-1:0];
                CFG_GAP_WIN:    r_gap_win    <= i_cfg_data[GAP_BITS-1:0];
                CFG_RUN_ROUNDS: r_run_rounds <= i_cfg_data[ROUND_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign above_high  = CMP_BITS'(i_sample) > CMP_BITS'(r_high_thr);
    assign below_low   = CMP_BITS'(i_sample) < CMP_BITS'(r_low_thr);
    assign count_inc   = r_window_count + GAP_BITS'(1);
    assign pulse_limit = GAP_BITS'(r_pulse_win);
    // a zero window runs out at once, same as a window of one
    assign pulse_out   = count_inc >= pulse_limit;
    assign gap_out     = count_inc >= r_gap_win;
    assign phase_sel   = r_run_dir ? (PHASE_BITS'(3) - r_phase) : r_phase;
    assign round_inc   = r_round + ROUND_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect       <= DET_IDLE;
            r_window_count <= '0;
            r_light        <= 1'b0;
            r_run_active   <= 1'b0;
            r_run_dir      <= 1'b0;
            r_phase        <= '0;
            r_round        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_detect       <= n_detect;
            r_window_count <= n_window_count;
            r_light        <= n_light;
            r_run_active   <= n_run_active;
            r_run_dir      <= n_run_dir;
            r_phase        <= n_phase;
            r_round        <= n_round;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coil      <= n_coil;
        r_light_out <= n_light_out;
        r_moving    <= n_moving;
        r_reverse   <= n_reverse;
    end

    always_comb begin
        n_detect       = r_detect;
        n_window_count = r_window_count;
        n_light        = r_light;
        n_run_active   = r_run_active;
        n_run_dir      = r_run_dir;
        n_phase        = r_phase;
        n_round        = r_round;
        n_out_valid    = r_out_valid && !i_result_ready;
        n_coil         = r_coil;
        n_light_out    = r_light_out;
        n_moving       = r_moving;
        n_reverse      = r_reverse;

        if (accept) begin
            n_out_valid = 1'b1;
            n_coil      = '0;
            n_moving    = 1'b0;
            n_reverse   = 1'b0;
            if (r_run_active) begin
                // step one coil phase; samples are dropped while running
                n_coil    = COIL_BITS'(1) << phase_sel;
                n_moving  = 1'b1;
                n_reverse = r_run_dir;
                n_phase   = r_phase + PHASE_BITS'(1);
                if (r_phase == PHASE_BITS'(3)) begin
                    n_round = round_inc;
                    if (round_inc == r_run_rounds) begin
                        n_run_active = 1'b0;
                        n_round      = '0;
                        n_light      = !r_light;
                    end
                end
            end else begin
                unique case (r_detect)
                    DET_IDLE: begin
                        if (above_high) begin
                            n_detect       = DET_FIRST;
                            n_window_count = '0;
                        end
                    end
                    DET_FIRST: begin
                        if (below_low) begin
                            n_detect       = DET_GAP;
                            n_window_count = '0;
                        end else if (pulse_out) begin
                            n_detect       = DET_IDLE;
                            n_window_count = '0;
                        end else begin
                            n_window_count = count_inc;
                        end
                    end
                    DET_GAP: begin
                        if (above_high) begin
                            n_detect       = DET_SECOND;
                            n_window_count = '0;
                        end else if (gap_out) begin
                            n_detect       = DET_IDLE;
                            n_window_count = '0;
                        end else begin
                            n_window_count = count_inc;
                        end
                    end
                    DET_SECOND: begin
                        if (below_low) begin
                            // double clap seen: start the run on the next word
                            n_detect       = DET_IDLE;
                            n_window_count = '0;
                            n_run_active   = 1'b1;
                            n_run_dir      = r_light;
                            n_phase        = '0;
                            n_round        = '0;
                        end else if (pulse_out) begin
                            n_detect       = DET_IDLE;
                            n_window_count = '0;
                        end else begin
                            n_window_count = count_inc;
                        end
                    end
                    default: begin
                        n_detect       = DET_IDLE;
                        n_window_count = '0;
                    end
                endcase
            end
            n_light_out = n_light;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_coil_drive   = r_coil;
    assign o_light_on     = r_light_out;
    assign o_moving       = r_moving;
    assign o_reverse      = r_reverse;

endmodule

>>> design/dcss_checker.sv
// Port-level checks of the double-clap stepper switch and their binding.
module dcss_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_result_valid,
    input logic                                i_result_ready,
    input logic [dcss_pkg::COIL_BITS-1:0]      o_coil_drive,
    input logic                                o_light_on,
    input logic                                o_moving,
    input logic                                o_reverse
);
    import dcss_pkg::*;

    // an idle motor drives no coil and shows no direction
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_moving) |-> (o_coil_drive == '0) && !o_reverse)
        else $error("coil or direction active without motion");

    // a moving word drives exactly one coil
    a_one_coil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_moving) |-> $onehot(o_coil_drive))
        else $error("moving word without a single coil");

    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !i_result_ready) |=>
            (o_result_valid && $stable(o_coil_drive) && $stable(o_light_on)
             && $stable(o_moving) && $stable(o_reverse)))
        else $error("stalled result word changed");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid right after reset");

endmodule

bind double_clap_stepper_switch dcss_checker u_dcss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .i_result_ready (i_result_ready),
    .o_coil_drive   (o_coil_drive),
    .o_light_on     (o_light_on),
    .o_moving       (o_moving),
    .o_reverse      (o_reverse)
);
